// ===== rtl/mlbt_pkg.sv =====
// shared types and constants of the mac learning bridge table
package mlbt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MAC_W       = 48;
  localparam int PORT_W      = 16;
  localparam int STAMP_W     = 32;
  localparam int AGE_W       = 16;

  localparam logic [AGE_W-1:0] AGEING_RESET = 16'd300;

  localparam logic       OP_FRAME = 1'b0;
  localparam logic       OP_TICK  = 1'b1;

  localparam logic [1:0] DEC_IGNORED   = 2'd0;
  localparam logic [1:0] DEC_FORWARD   = 2'd1;
  localparam logic [1:0] DEC_BROADCAST = 2'd2;
  localparam logic [1:0] DEC_NOPORT    = 2'd3;

  typedef struct packed {
    logic              op;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] in_port;
  } req_t;

  typedef struct packed {
    logic [1:0]        decision;
    logic [PORT_W-1:0] out_port;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [PORT_W-1:0]  port;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/mlbt_ram.sv =====
// generic single write port ram with registered read
module mlbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/mac_learning_bridge_table.sv =====
// top level of the mac learning bridge table
// A tick request only advances the seconds counter. A frame request walks the entry ram
// through its single read port in phases: learning, destination lookup, broadcast
// listing and ageing. Lookup and listing are skipped when source equals destination or
// the table holds a single entry, and listing is skipped on a lookup hit. Each entry is
// read in one state and checked in the next, each walk closes in its read state, and a
// stalled result side holds the walk. No new request is taken meanwhile.
module mac_learning_bridge_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mlbt_pkg::req_t                  in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mlbt_pkg::rsp_t                  out_o,
  input  logic                            cfg_we_i,
  input  logic [mlbt_pkg::AGE_W-1:0]      cfg_wdata_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LRD  = 4'd1;
  localparam logic [3:0] S_LCHK = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_FRD  = 4'd4;
  localparam logic [3:0] S_FCHK = 4'd5;
  localparam logic [3:0] S_BRD  = 4'd6;
  localparam logic [3:0] S_BCHK = 4'd7;
  localparam logic [3:0] S_ARD  = 4'd8;
  localparam logic [3:0] S_ACHK = 4'd9;

  logic [3:0]                     state_q, state_d;
  logic [mlbt_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [mlbt_pkg::CNT_W-1:0]     wr_q, wr_d;
  logic [mlbt_pkg::CNT_W-1:0]     count_q, count_d;
  logic [mlbt_pkg::STAMP_W-1:0]   seconds_q, seconds_d;
  logic [mlbt_pkg::AGE_W-1:0]     ageing_q;
  mlbt_pkg::req_t                 req_q, req_d;
  logic                           pend_q, pend_d;
  logic [mlbt_pkg::PORT_W-1:0]    pend_port_q, pend_port_d;
  logic                           out_valid_q;
  mlbt_pkg::rsp_t                 out_q;

  logic                           emit;
  mlbt_pkg::rsp_t                 emit_rsp;
  logic                           out_free;
  logic                           we;
  logic [mlbt_pkg::IDX_W-1:0]     waddr;
  mlbt_pkg::entry_t               wdata;
  mlbt_pkg::entry_t               rdata;
  logic [mlbt_pkg::STAMP_W-1:0]   age;

  mlbt_ram #(
    .WIDTH(mlbt_pkg::ENTRY_W),
    .DEPTH(mlbt_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx_q[mlbt_pkg::IDX_W-1:0]),
    .rdata_o(rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign age         = seconds_q - rdata.stamp;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    count_d     = count_q;
    seconds_d   = seconds_q;
    req_d       = req_q;
    pend_d      = pend_q;
    pend_port_d = pend_port_q;
    emit        = 1'b0;
    emit_rsp    = '0;
    we          = 1'b0;
    waddr       = idx_q[mlbt_pkg::IDX_W-1:0];
    wdata       = '{mac: req_q.src_mac, port: req_q.in_port, stamp: seconds_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_i.op == mlbt_pkg::OP_TICK) begin
            seconds_d = seconds_q + 32'd1;
          end else begin
            req_d   = in_i;
            idx_d   = '0;
            state_d = S_LRD;
          end
        end
      end
      S_LRD: begin
        if (idx_q == count_q) begin
          if (count_q < mlbt_pkg::CNT_W'(mlbt_pkg::TABLE_DEPTH)) begin
            we      = 1'b1;
            waddr   = count_q[mlbt_pkg::IDX_W-1:0];
            count_d = count_q + mlbt_pkg::CNT_W'(1);
          end
          state_d = S_DEC;
        end else begin
          state_d = S_LCHK;
        end
      end
      S_LCHK: begin
        if (rdata.mac == req_q.src_mac) begin
          we      = 1'b1;
          state_d = S_DEC;
        end else begin
          idx_d   = idx_q + mlbt_pkg::CNT_W'(1);
          state_d = S_LRD;
        end
      end
      S_DEC: begin
        idx_d  = '0;
        wr_d   = '0;
        pend_d = 1'b0;
        priority if (req_q.src_mac == req_q.dst_mac) begin
          emit_rsp = '{decision: mlbt_pkg::DEC_IGNORED, out_port: '0, last: 1'b1};
          emit     = out_free;
          if (out_free) state_d = S_ARD;
        end else if (count_q == mlbt_pkg::CNT_W'(1)) begin
          emit_rsp = '{decision: mlbt_pkg::DEC_NOPORT, out_port: '0, last: 1'b1};
          emit     = out_free;
          if (out_free) state_d = S_ARD;
        end else begin
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        if (idx_q == count_q) begin
          idx_d   = '0;
          state_d = S_BRD;
        end else begin
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (rdata.mac == req_q.dst_mac) begin
          emit_rsp = '{decision: mlbt_pkg::DEC_FORWARD, out_port: rdata.port, last: 1'b1};
          emit     = out_free;
          if (out_free) begin
            idx_d   = '0;
            state_d = S_ARD;
          end
        end else begin
          idx_d   = idx_q + mlbt_pkg::CNT_W'(1);
          state_d = S_FRD;
        end
      end
      S_BRD: begin
        if (idx_q == count_q) begin
          if (pend_q) begin
            emit_rsp = '{decision: mlbt_pkg::DEC_BROADCAST, out_port: pend_port_q,
                         last: 1'b1};
          end else begin
            emit_rsp = '{decision: mlbt_pkg::DEC_NOPORT, out_port: '0, last: 1'b1};
          end
          emit = out_free;
          if (out_free) begin
            idx_d   = '0;
            state_d = S_ARD;
          end
        end else begin
          state_d = S_BCHK;
        end
      end
      S_BCHK: begin
        if (rdata.port != req_q.in_port) begin
          if (!pend_q) begin
            pend_d      = 1'b1;
            pend_port_d = rdata.port;
            idx_d       = idx_q + mlbt_pkg::CNT_W'(1);
            state_d     = S_BRD;
          end else if (out_free) begin
            emit_rsp    = '{decision: mlbt_pkg::DEC_BROADCAST, out_port: pend_port_q,
                            last: 1'b0};
            emit        = 1'b1;
            pend_port_d = rdata.port;
            idx_d       = idx_q + mlbt_pkg::CNT_W'(1);
            state_d     = S_BRD;
          end
        end else begin
          idx_d   = idx_q + mlbt_pkg::CNT_W'(1);
          state_d = S_BRD;
        end
      end
      S_ARD: begin
        if (idx_q == count_q) begin
          count_d = wr_q;
          state_d = S_IDLE;
        end else begin
          state_d = S_ACHK;
        end
      end
      S_ACHK: begin
        if (age <= {16'd0, ageing_q}) begin
          we    = 1'b1;
          waddr = wr_q[mlbt_pkg::IDX_W-1:0];
          wdata = rdata;
          wr_d  = wr_q + mlbt_pkg::CNT_W'(1);
        end
        idx_d   = idx_q + mlbt_pkg::CNT_W'(1);
        state_d = S_ARD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      seconds_q   <= '0;
      ageing_q    <= mlbt_pkg::AGEING_RESET;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      idx_q       <= '0;
      wr_q        <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      seconds_q <= seconds_d;
      pend_q    <= pend_d;
      idx_q     <= idx_d;
      wr_q      <= wr_d;
      if (cfg_we_i) begin
        ageing_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    pend_port_q <= pend_port_d;
    if (emit) begin
      out_q <= emit_rsp;
    end
  end

endmodule

// ===== bench/mac_learning_bridge_table_tb.sv =====
// testbench of the mac learning bridge table: directed and random frames and ticks checked against a table model
`timescale 1ns / 100ps

class bridge_scoreboard;
  logic [mlbt_pkg::MAC_W-1:0]   tbl_mac[$];
  logic [mlbt_pkg::PORT_W-1:0]  tbl_port[$];
  logic [mlbt_pkg::STAMP_W-1:0] tbl_stamp[$];
  logic [mlbt_pkg::STAMP_W-1:0] now_sec;
  logic [mlbt_pkg::AGE_W-1:0]   age_limit;
  mlbt_pkg::rsp_t               pending[$];
  int                           n_err;

  function new();
    now_sec = '0;
    age_limit = mlbt_pkg::AGEING_RESET;
    n_err = 0;
  endfunction

  function void learn_mac(logic [mlbt_pkg::MAC_W-1:0] mac, logic [mlbt_pkg::PORT_W-1:0] port);
    foreach (tbl_mac[i]) begin
      if (tbl_mac[i] == mac) begin
        tbl_port[i] = port;
        tbl_stamp[i] = now_sec;
        return;
      end
    end
    if (tbl_mac.size() < mlbt_pkg::TABLE_DEPTH) begin
      tbl_mac.push_back(mac);
      tbl_port.push_back(port);
      tbl_stamp.push_back(now_sec);
    end
  endfunction

  function void push_decision(logic [1:0] dec, logic [mlbt_pkg::PORT_W-1:0] port);
    mlbt_pkg::rsp_t r;
    r.decision = dec;
    r.out_port = port;
    r.last = 1'b0;
    pending.push_back(r);
  endfunction

  function void note_request(mlbt_pkg::req_t rq);
    int n0;
    int w;
    bit hit;
    if (rq.op == mlbt_pkg::OP_TICK) begin
      now_sec = now_sec + 32'd1;
      return;
    end
    learn_mac(rq.src_mac, rq.in_port);
    n0 = pending.size();
    hit = 0;
    if (rq.src_mac == rq.dst_mac) push_decision(mlbt_pkg::DEC_IGNORED, '0);
    else if (tbl_mac.size() == 1) push_decision(mlbt_pkg::DEC_NOPORT, '0);
    else begin
      foreach (tbl_mac[i]) begin
        if (!hit && tbl_mac[i] == rq.dst_mac) begin
          push_decision(mlbt_pkg::DEC_FORWARD, tbl_port[i]);
          hit = 1;
        end
      end
      if (!hit) begin
        foreach (tbl_port[i])
          if (tbl_port[i] != rq.in_port) push_decision(mlbt_pkg::DEC_BROADCAST, tbl_port[i]);
        if (pending.size() == n0) push_decision(mlbt_pkg::DEC_NOPORT, '0);
      end
    end
    pending[pending.size()-1].last = 1'b1;
    w = 0;
    for (int r = 0; r < tbl_mac.size(); r++) begin
      if (mlbt_pkg::STAMP_W'(now_sec - tbl_stamp[r]) <= {16'd0, age_limit}) begin
        tbl_mac[w] = tbl_mac[r];
        tbl_port[w] = tbl_port[r];
        tbl_stamp[w] = tbl_stamp[r];
        w++;
      end
    end
    while (tbl_mac.size() > w) begin
      void'(tbl_mac.pop_back());
      void'(tbl_port.pop_back());
      void'(tbl_stamp.pop_back());
    end
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_err++;
  endtask

  task check_result(mlbt_pkg::rsp_t got);
    mlbt_pkg::rsp_t want;
    if (pending.size() == 0) begin
      report("unexpected result", 32'(got.decision), 32'd0);
      return;
    end
    want = pending.pop_front();
    if (got.decision !== want.decision)
      report("decision", 32'(got.decision), 32'(want.decision));
    if (got.out_port !== want.out_port)
      report("out_port", 32'(got.out_port), 32'(want.out_port));
    if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
  endtask
endclass

module mac_learning_bridge_table_tb;
  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  mlbt_pkg::req_t               in_req;
  logic                         out_valid;
  logic                         out_stall;
  mlbt_pkg::rsp_t               out_rsp;
  logic                         cfg_we;
  logic [mlbt_pkg::AGE_W-1:0]   cfg_wdata;

  bridge_scoreboard             sb;
  int                           cycle_cnt;
  bit                           stall_hold;
  logic [mlbt_pkg::MAC_W-1:0]   mac_pool[8];

  mac_learning_bridge_table i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_o(out_rsp),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [mlbt_pkg::MAC_W-1:0] rand_mac();
    return mlbt_pkg::MAC_W'({$urandom, $urandom});
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_rsp);
    if (stall_hold) out_stall <= 1'b0;
    else out_stall <= (gap_len() != 0);
    if (cycle_cnt > 2000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(mlbt_pkg::req_t rq);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= rq;
    do @(posedge clk); while (in_stall);
    sb.note_request(rq);
  endtask

  task automatic send_frame(logic [mlbt_pkg::MAC_W-1:0] s, logic [mlbt_pkg::MAC_W-1:0] d,
                            logic [mlbt_pkg::PORT_W-1:0] p);
    mlbt_pkg::req_t rq;
    rq.op = mlbt_pkg::OP_FRAME;
    rq.src_mac = s;
    rq.dst_mac = d;
    rq.in_port = p;
    send_request(rq);
  endtask

  task automatic send_ticks(int n);
    mlbt_pkg::req_t rq;
    rq = '0;
    rq.op = mlbt_pkg::OP_TICK;
    rq.src_mac = rand_mac();
    repeat (n) send_request(rq);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6 * mlbt_pkg::TABLE_DEPTH + 20) @(posedge clk);
  endtask

  task automatic write_ageing(logic [mlbt_pkg::AGE_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.age_limit = v;
  endtask

  task automatic random_phase(int n);
    logic [mlbt_pkg::MAC_W-1:0] s, d;
    logic [mlbt_pkg::PORT_W-1:0] p;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 5) == 0) send_ticks($urandom_range(1, 4));
      else begin
        s = ($urandom_range(0, 7) == 0) ? rand_mac() : mac_pool[$urandom_range(0, 7)];
        d = ($urandom_range(0, 5) == 0) ? rand_mac() : mac_pool[$urandom_range(0, 7)];
        p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
        send_frame(s, d, p);
      end
    end
  endtask

  initial begin
    sb = new();
    cycle_cnt = 0;
    stall_hold = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    foreach (mac_pool[i]) mac_pool[i] = rand_mac();
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lone entry, same address, hit, miss, extremes
    send_frame(48'h0, 48'hffff_ffff_ffff, 16'd1);
    send_frame(48'h1234, 48'h1234, 16'hffff);
    send_frame(48'hffff_ffff_ffff, 48'h0, 16'hffff);
    send_frame(48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 16'd2);
    send_frame(48'haaaa_aaaa_aaaa, 48'h7777, 16'd2);
    send_frame(48'h7777, 48'h8888, 16'h8000);
    send_ticks(2);
    write_ageing(16'd0);
    send_frame(48'h9999, 48'h1, 16'd3);
    send_frame(48'h9999, 48'h2, 16'd3);
    write_ageing(16'd2);
    for (int i = 0; i < 34; i++)
      send_frame(48'h100 + 48'(i), 48'h100 + 48'(i + 1), 16'(i % 5 + 1));
    send_ticks(3);
    send_frame(48'h100, 48'h200, 16'd1);
    write_ageing(16'hffff);

    stall_hold = 1;
    drain();
    stall_hold = 0;
    random_phase(25);
    write_ageing(16'd1);
    random_phase(20);
    write_ageing(16'd5);
    random_phase(20);

    drain();
    if (sb.n_err == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
